FILE: rtl/rbtr_pkg.sv
// Shared types, constants and sequencer states of the regen braking torque ramp.
`timescale 1ns / 1ps
`default_nettype none

package rbtr_pkg;

  // Field and register widths.
  localparam int SPEED_W   = 16;
  localparam int VOLT_W    = 16;
  localparam int TORQUE_W  = 16;
  localparam int PCT_W     = 7;
  localparam int CUR_W     = 16;
  localparam int MINSPD_W  = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Serial multiplier: multiplicand, multiplier (MSB aligned) and product widths.
  localparam int MUL_X_W = 39;
  localparam int MUL_Y_W = 20;
  localparam int MUL_P_W = MUL_X_W + MUL_Y_W;

  // Serial divider: remainder/divisor, dividend and quotient widths.
  localparam int DIV_R_W = 15;
  localparam int DIV_D_W = 16;
  localparam int DIV_Q_W = 16;

  // 30/pi in Q16 and the percent divisor.
  localparam logic [MUL_Y_W-1:0] THIRTY_OVER_PI_Q16 = 20'd625822;
  localparam logic [DIV_R_W-1:0] PERCENT_DIV        = 15'd100;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REGEN_ON        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_PERCENT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERCENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BUS_VOLTAGE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED       = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LVL,
    ST_MUL_VOLT,
    ST_MUL_K,
    ST_DIV_LIM,
    ST_MUL_RAMP,
    ST_DIV_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic run;
  } mul_ctrl_t;

  typedef struct packed {
    logic load;
    logic run;
  } div_ctrl_t;

  // Number of shift-and-add or shift-and-subtract steps taken in each state.
  function automatic logic [4:0] run_len(state_t s);
    logic [4:0] n;
    unique case (s)
      ST_MUL_LVL:  n = 5'd7;
      ST_MUL_VOLT: n = 5'd16;
      ST_MUL_K:    n = 5'd20;
      ST_DIV_LIM:  n = 5'd15;
      ST_MUL_RAMP: n = 5'd7;
      ST_DIV_STEP: n = 5'd16;
      default:     n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rbtr_mul.sv
// Bit-serial unsigned multiplier, one multiplier bit per cycle while run is high, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module rbtr_mul (
  input  wire logic                           clk,
  input  wire rbtr_pkg::mul_ctrl_t            ctrl,
  input  wire logic [rbtr_pkg::MUL_X_W-1:0]   x_in,
  input  wire logic [rbtr_pkg::MUL_Y_W-1:0]   y_in,
  output logic      [rbtr_pkg::MUL_P_W-1:0]   product
);

  logic [rbtr_pkg::MUL_X_W-1:0] x;
  logic [rbtr_pkg::MUL_Y_W-1:0] y;
  logic [rbtr_pkg::MUL_P_W-1:0] acc;
  logic [rbtr_pkg::MUL_P_W-1:0] addend;

  // The multiplier is left aligned, so its top bit is the next digit to use.
  assign addend = y[rbtr_pkg::MUL_Y_W-1] ?
                  {{rbtr_pkg::MUL_Y_W{1'b0}}, x} : '0;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x   <= x_in;
      y   <= y_in;
      acc <= '0;
    end else if (ctrl.run) begin
      acc <= {acc[rbtr_pkg::MUL_P_W-2:0], 1'b0} + addend;
      y   <= {y[rbtr_pkg::MUL_Y_W-2:0], 1'b0};
    end
  end

  assign product = acc;

endmodule

`default_nettype wire

FILE: rtl/rbtr_div.sv
// Restoring serial divider, one quotient bit per cycle while run is high.
`timescale 1ns / 1ps
`default_nettype none

module rbtr_div (
  input  wire logic                           clk,
  input  wire rbtr_pkg::div_ctrl_t            ctrl,
  input  wire logic [rbtr_pkg::DIV_R_W-1:0]   rem_init,
  input  wire logic [rbtr_pkg::DIV_D_W-1:0]   dividend,
  input  wire logic [rbtr_pkg::DIV_R_W-1:0]   divisor,
  output logic      [rbtr_pkg::DIV_Q_W-1:0]   quotient
);

  logic [rbtr_pkg::DIV_R_W-1:0] rem;
  logic [rbtr_pkg::DIV_D_W-1:0] dsr;
  logic [rbtr_pkg::DIV_R_W-1:0] dvs;
  logic [rbtr_pkg::DIV_Q_W-1:0] q;
  logic [rbtr_pkg::DIV_R_W+1:0] trial;
  logic                         fits;

  // The partial remainder stays below the divisor, so the shifted value needs one
  // more bit and the borrow one more again.
  assign trial = {1'b0, rem, dsr[rbtr_pkg::DIV_D_W-1]} - {2'b00, dvs};
  assign fits  = !trial[rbtr_pkg::DIV_R_W+1];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= rem_init;
      dsr <= dividend;
      dvs <= divisor;
      q   <= '0;
    end else if (ctrl.run) begin
      rem <= fits ? trial[rbtr_pkg::DIV_R_W-1:0]
                  : {rem[rbtr_pkg::DIV_R_W-2:0], dsr[rbtr_pkg::DIV_D_W-1]};
      dsr <= {dsr[rbtr_pkg::DIV_D_W-2:0], 1'b0};
      q   <= {q[rbtr_pkg::DIV_Q_W-2:0], fits};
    end
  end

  assign quotient = q;

endmodule

`default_nettype wire

FILE: rtl/regen_braking_torque_ramp.sv
// Top level of the regenerative braking torque ramp.
`timescale 1ns / 1ps
`default_nettype none

// Regenerative braking torque ramp. Each input transaction carries a motor speed
// and a DC bus voltage and yields exactly one output transaction with a torque
// command in -32768..0. When regen is disabled the result is zero and the stored
// torque is cleared; a positive max current, a bus voltage above its limit, or a
// speed of zero or below give zero and keep the stored torque. Otherwise the
// torque limit level * max_current * voltage * (625822 / 65536) / speed is found,
// saturated to -32768..0, and the ramp step is limit * ramp_percent / 100, both
// truncated toward zero. Above 1.5 times the minimum speed the torque steps toward
// the limit, below the minimum speed it steps back toward zero, and in between it
// holds. One item is worked at a time. An item that updates the torque passes
// through a bit-serial multiplier that takes one multiplier bit per cycle
// (7 + 16 + 20 + 7 steps) and a restoring serial divider that takes one quotient
// bit per cycle (15 + 16 steps), with a load of the unit ahead of each pass. The
// other items skip the arithmetic. A finished result sits in an output register,
// and the next item is accepted while it waits to be taken.
// Configuration must be written only while no item is in flight; a write takes
// effect at the clock edge that carries it.

module regen_braking_torque_ramp (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] motor_speed, [31:16] bus_voltage
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [15:0] regen_torque
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [rbtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbtr_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic                               regen_on;
  logic [rbtr_pkg::PCT_W-1:0]         level_percent;
  logic signed [rbtr_pkg::CUR_W-1:0]  max_current;
  logic [rbtr_pkg::PCT_W-1:0]         ramp_percent;
  logic [rbtr_pkg::VOLT_W-1:0]        max_bus_voltage;
  logic [rbtr_pkg::MINSPD_W-1:0]      min_speed;

  // Sequencer and item state.
  rbtr_pkg::state_t                   state, state_next;
  logic [4:0]                         cnt;
  logic signed [rbtr_pkg::TORQUE_W-1:0] torque_now;
  logic [rbtr_pkg::MINSPD_W-1:0]      speed_r;
  logic [rbtr_pkg::VOLT_W-1:0]        volt_r;
  logic                               above_r;
  logic                               comp_r;
  logic                               zero_r;
  logic                               sat_r;
  logic [rbtr_pkg::TORQUE_W-1:0]      lim_mag_r;
  logic                               m_valid;
  logic [rbtr_pkg::TORQUE_W-1:0]      m_data;

  // Arithmetic units.
  rbtr_pkg::mul_ctrl_t                mul_ctrl;
  rbtr_pkg::div_ctrl_t                div_ctrl;
  logic [rbtr_pkg::MUL_X_W-1:0]       mul_x;
  logic [rbtr_pkg::MUL_Y_W-1:0]       mul_y;
  logic [rbtr_pkg::MUL_P_W-1:0]       product;
  logic [rbtr_pkg::DIV_R_W-1:0]       div_rem;
  logic [rbtr_pkg::DIV_D_W-1:0]       div_dividend;
  logic [rbtr_pkg::DIV_R_W-1:0]       div_divisor;
  logic [rbtr_pkg::DIV_Q_W-1:0]       quotient;

  // Input decode and the special cases, judged at acceptance.
  logic signed [rbtr_pkg::SPEED_W-1:0] in_speed;
  logic [rbtr_pkg::VOLT_W-1:0]         in_volt;
  logic                                in_accept;
  logic                                cur_positive;
  logic                                speed_pos;
  logic                                in_above;
  logic                                in_below;
  logic                                go_compute;
  logic                                out_free;
  logic                                step_done;
  logic [rbtr_pkg::CUR_W-1:0]          cur_mag;
  logic [rbtr_pkg::TORQUE_W-1:0]       lim_mag_c;
  logic                                sat_c;

  // Torque update.
  logic signed [17:0]                  t_ext;
  logic signed [17:0]                  step_ext;
  logic signed [17:0]                  lim_ext;
  logic signed [17:0]                  nx;
  logic signed [17:0]                  t_new;
  logic [rbtr_pkg::TORQUE_W-1:0]       result;

  assign in_speed  = s_axis_tdata[15:0];
  assign in_volt   = s_axis_tdata[31:16];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid || m_axis_tready;

  assign cur_positive = !max_current[rbtr_pkg::CUR_W-1] && (max_current != '0);
  assign speed_pos    = !in_speed[rbtr_pkg::SPEED_W-1] && (in_speed != '0);
  // Above means 2 * speed > 3 * min_speed; below means speed < min_speed.
  assign in_above = {1'b0, in_speed[14:0], 1'b0} >
                    ({2'b00, min_speed} + {1'b0, min_speed, 1'b0});
  assign in_below = in_speed[14:0] < min_speed;
  assign go_compute = regen_on && !cur_positive && (in_volt <= max_bus_voltage) &&
                      speed_pos && (in_above || in_below);

  // Magnitude of the current; the two's complement of -32768 reads as 32768.
  assign cur_mag = ~max_current + 16'd1;

  // The limit saturates once the quotient would reach 32768, that is when the
  // Q16-scaled numerator shifted down by 15 more bits is at least the speed.
  assign sat_c     = product[rbtr_pkg::MUL_P_W-1:31] >= {13'd0, speed_r};
  assign lim_mag_c = sat_r ? 16'h8000 : {1'b0, quotient[14:0]};

  assign step_done = (cnt == rbtr_pkg::run_len(state));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rbtr_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = go_compute ? rbtr_pkg::ST_MUL_LVL : rbtr_pkg::ST_DONE;
        end
      end
      rbtr_pkg::ST_MUL_LVL:  if (step_done) state_next = rbtr_pkg::ST_MUL_VOLT;
      rbtr_pkg::ST_MUL_VOLT: if (step_done) state_next = rbtr_pkg::ST_MUL_K;
      rbtr_pkg::ST_MUL_K:    if (step_done) state_next = rbtr_pkg::ST_DIV_LIM;
      rbtr_pkg::ST_DIV_LIM:  if (step_done) state_next = rbtr_pkg::ST_MUL_RAMP;
      rbtr_pkg::ST_MUL_RAMP: if (step_done) state_next = rbtr_pkg::ST_DIV_STEP;
      rbtr_pkg::ST_DIV_STEP: if (step_done) state_next = rbtr_pkg::ST_DONE;
      rbtr_pkg::ST_DONE:     if (out_free)  state_next = rbtr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit control and operand selection. The first cycle of
  // each arithmetic state loads the unit, the rest step it.
  always_comb begin
    s_axis_tready = 1'b0;
    mul_ctrl      = '0;
    div_ctrl      = '0;
    mul_x         = '0;
    mul_y         = '0;
    div_rem       = '0;
    div_dividend  = '0;
    div_divisor   = rbtr_pkg::PERCENT_DIV;
    unique case (state)
      rbtr_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      rbtr_pkg::ST_MUL_LVL: begin
        mul_ctrl.load = (cnt == 5'd0);
        mul_ctrl.run  = (cnt != 5'd0);
        mul_x         = {23'd0, cur_mag};
        mul_y         = {level_percent, 13'd0};
      end
      rbtr_pkg::ST_MUL_VOLT: begin
        mul_ctrl.load = (cnt == 5'd0);
        mul_ctrl.run  = (cnt != 5'd0);
        mul_x         = product[rbtr_pkg::MUL_X_W-1:0];
        mul_y         = {volt_r, 4'd0};
      end
      rbtr_pkg::ST_MUL_K: begin
        mul_ctrl.load = (cnt == 5'd0);
        mul_ctrl.run  = (cnt != 5'd0);
        mul_x         = product[rbtr_pkg::MUL_X_W-1:0];
        mul_y         = rbtr_pkg::THIRTY_OVER_PI_Q16;
      end
      rbtr_pkg::ST_DIV_LIM: begin
        // Dropping the low 16 bits first is exact for a truncating quotient.
        // Without saturation the bits above 45 are zero.
        div_ctrl.load = (cnt == 5'd0);
        div_ctrl.run  = (cnt != 5'd0);
        div_rem       = product[45:31];
        div_dividend  = {product[30:16], 1'b0};
        div_divisor   = speed_r;
      end
      rbtr_pkg::ST_MUL_RAMP: begin
        mul_ctrl.load = (cnt == 5'd0);
        mul_ctrl.run  = (cnt != 5'd0);
        mul_x         = {23'd0, lim_mag_c};
        mul_y         = {ramp_percent, 13'd0};
      end
      rbtr_pkg::ST_DIV_STEP: begin
        // The product is below 2^22, so its top six bits stay under 100.
        div_ctrl.load = (cnt == 5'd0);
        div_ctrl.run  = (cnt != 5'd0);
        div_rem       = {9'd0, product[21:16]};
        div_dividend  = product[15:0];
        div_divisor   = rbtr_pkg::PERCENT_DIV;
      end
      rbtr_pkg::ST_DONE: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Torque update: step toward the limit above, back toward zero below; else give zero or hold.
  always_comb begin
    t_ext    = {{2{torque_now[rbtr_pkg::TORQUE_W-1]}}, torque_now};
    step_ext = {2'b00, quotient};
    lim_ext  = -$signed({2'b00, lim_mag_r});
    if (above_r) begin
      nx    = t_ext - step_ext;
      t_new = (nx > lim_ext) ? nx : lim_ext;
    end else begin
      nx    = t_ext + step_ext;
      t_new = (nx < 18'sd0) ? nx : 18'sd0;
    end
    if (comp_r) begin
      result = t_new[rbtr_pkg::TORQUE_W-1:0];
    end else if (zero_r) begin
      result = '0;
    end else begin
      result = torque_now;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= rbtr_pkg::ST_IDLE;
      cnt             <= '0;
      torque_now      <= '0;
      m_valid         <= 1'b0;
      regen_on        <= 1'b0;
      level_percent   <= '0;
      max_current     <= '0;
      ramp_percent    <= '0;
      max_bus_voltage <= '0;
      min_speed       <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 5'd0 : cnt + 5'd1;

      if (cfg_we) begin
        unique case (cfg_index)
          rbtr_pkg::REG_REGEN_ON:        regen_on        <= cfg_wdata[0];
          rbtr_pkg::REG_LEVEL_PERCENT:   level_percent   <= cfg_wdata[rbtr_pkg::PCT_W-1:0];
          rbtr_pkg::REG_MAX_CURRENT:     max_current     <= cfg_wdata;
          rbtr_pkg::REG_RAMP_PERCENT:    ramp_percent    <= cfg_wdata[rbtr_pkg::PCT_W-1:0];
          rbtr_pkg::REG_MAX_BUS_VOLTAGE: max_bus_voltage <= cfg_wdata;
          rbtr_pkg::REG_MIN_SPEED:       min_speed       <= cfg_wdata[rbtr_pkg::MINSPD_W-1:0];
          default: ;
        endcase
      end

      // Disabled regen clears the stored torque as soon as the item arrives.
      if (in_accept && !regen_on) begin
        torque_now <= '0;
      end else if (state == rbtr_pkg::ST_DONE && out_free && comp_r) begin
        torque_now <= t_new[rbtr_pkg::TORQUE_W-1:0];
      end

      if (state == rbtr_pkg::ST_DONE && out_free) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      speed_r <= in_speed[14:0];
      volt_r  <= in_volt;
      above_r <= in_above;
      comp_r  <= go_compute;
      // Zero for every special case except the hold band.
      zero_r  <= !(regen_on && !cur_positive && (in_volt <= max_bus_voltage) &&
                   speed_pos);
    end
    if (state == rbtr_pkg::ST_DIV_LIM && cnt == 5'd0) begin
      sat_r <= sat_c;
    end
    if (state == rbtr_pkg::ST_MUL_RAMP && cnt == 5'd0) begin
      lim_mag_r <= lim_mag_c;
    end
    if (state == rbtr_pkg::ST_DONE && out_free) begin
      m_data <= result;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  rbtr_mul u_mul (
    .clk     (clk),
    .ctrl    (mul_ctrl),
    .x_in    (mul_x),
    .y_in    (mul_y),
    .product (product)
  );

  rbtr_div u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .rem_init (div_rem),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient)
  );

endmodule

`default_nettype wire

FILE: rtl/rbtr_checker.sv
// Port-level checks of the regen braking torque ramp, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rbtr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // The torque command is never positive.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15] || m_axis_tdata == 16'd0))
    else $error("positive torque command");

  // Only one item is worked at a time.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // A result that is not taken stays put.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("waiting result changed");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

endmodule

bind regen_braking_torque_ramp rbtr_checker u_rbtr_checker (.*);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the regenerative braking torque ramp.
`timescale 1ns / 1ps

// The bench drives motor speed and bus voltage transactions into the ramp and
// checks every torque transaction that comes back. The first part walks a
// fixed table of configuration writes and items. That table covers reset
// values, field extremes, saturation, zero and backward speed, voltage above
// the limit, positive max current, regen disabled, out-of-range percentages
// and writes to unused register indexes. The second part runs phases of
// random settings, each followed by a burst of random items. A local model of
// the torque state turns every accepted item into the torque that should come
// back, and a queue holds those values in order. Both stream sides idle at
// random. One phase runs with no idling at all. In another phase the output
// side holds off long enough for the block to stall its input.
module testbench;

  localparam longint TORQUE_K_Q16 = 625822;   // 30/pi in Q16
  localparam int     PCT_SCALE    = 100;
  localparam int     IDLE_PCT     = 28;
  localparam int     PHASE_COUNT  = 12;
  localparam int     PHASE_ITEMS  = 160;
  localparam int     HOLD_CYCLES  = 600;

  // Register indexes that the block must ignore.
  localparam logic [rbtr_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rbtr_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // A directed row is either one item (a = speed, b = voltage) or one register
  // write (a = index, b = data). When typed is set, want is the torque that
  // must come back; otherwise the local model supplies it.
  typedef struct packed {
    row_kind_t          kind;
    logic [15:0]        a;
    logic [15:0]        b;
    logic               typed;
    logic signed [15:0] want;
  } dir_row_t;

  localparam int PLAN_LEN = 43;
  localparam dir_row_t PLAN [PLAN_LEN] = '{
    // Straight out of reset regen is disabled, so any item gives zero.
    '{ROW_ITEM, 16'd1000,           16'd100,   1'b1, 16'sd0},
    '{ROW_ITEM, 16'h8000,           16'hFFFF,  1'b1, 16'sd0},
    // Strongest settings.
    '{ROW_CFG,  16'(rbtr_pkg::REG_REGEN_ON),        16'd1,     1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_LEVEL_PERCENT),   16'd100,   1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_MAX_CURRENT),     16'h8000,  1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_RAMP_PERCENT),    16'd100,   1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_MAX_BUS_VOLTAGE), 16'hFFFF,  1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_MIN_SPEED),       16'd0,     1'b0, 16'sd0},
    // Zero speed and backward speed give zero without touching the state.
    '{ROW_ITEM, 16'd0,              16'd500,   1'b1, 16'sd0},
    '{ROW_ITEM, 16'hFFFF,           16'd500,   1'b1, 16'sd0},
    // Slowest speed at full voltage saturates the limit and the full step.
    '{ROW_ITEM, 16'd1,              16'hFFFF,  1'b1, 16'sh8000},
    '{ROW_ITEM, 16'h7FFF,           16'd1,     1'b0, 16'sd0},
    '{ROW_ITEM, 16'h7FFF,           16'hFFFF,  1'b0, 16'sd0},
    // Voltage just above and exactly at the limit.
    '{ROW_CFG,  16'(rbtr_pkg::REG_MAX_BUS_VOLTAGE), 16'd1000,  1'b0, 16'sd0},
    '{ROW_ITEM, 16'd200,            16'd1001,  1'b1, 16'sd0},
    '{ROW_ITEM, 16'd200,            16'd1000,  1'b0, 16'sd0},
    // Largest minimum speed: top speed holds, slowest speed ramps back.
    '{ROW_CFG,  16'(rbtr_pkg::REG_MIN_SPEED),       16'h7FFF,  1'b0, 16'sd0},
    '{ROW_ITEM, 16'h7FFF,           16'd1000,  1'b0, 16'sd0},
    '{ROW_ITEM, 16'd1,              16'd1000,  1'b0, 16'sd0},
    // A positive max current forces zero; zero current gives a zero limit.
    '{ROW_CFG,  16'(rbtr_pkg::REG_MAX_CURRENT),     16'h7FFF,  1'b0, 16'sd0},
    '{ROW_ITEM, 16'd500,            16'd800,   1'b1, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_MAX_CURRENT),     16'd0,     1'b0, 16'sd0},
    '{ROW_ITEM, 16'd500,            16'd800,   1'b0, 16'sd0},
    // Out-of-range percentages are used as given. Speeds sit on both sides
    // of the 1.5x threshold and just under the minimum.
    '{ROW_CFG,  16'(rbtr_pkg::REG_MAX_CURRENT),     16'h8000,  1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_LEVEL_PERCENT),   16'd127,   1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_RAMP_PERCENT),    16'd127,   1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_MIN_SPEED),       16'd100,   1'b0, 16'sd0},
    '{ROW_ITEM, 16'd151,            16'd0,     1'b0, 16'sd0},
    '{ROW_ITEM, 16'd151,            16'd1000,  1'b0, 16'sd0},
    '{ROW_ITEM, 16'd150,            16'd1000,  1'b0, 16'sd0},
    '{ROW_ITEM, 16'd99,             16'd1000,  1'b0, 16'sd0},
    // Writes to unused indexes must change nothing.
    '{ROW_CFG,  16'(REG_SPARE_LO),                  16'hFFFF,  1'b0, 16'sd0},
    '{ROW_CFG,  16'(REG_SPARE_HI),                  16'h0000,  1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_MAX_BUS_VOLTAGE), 16'd0,     1'b0, 16'sd0},
    '{ROW_ITEM, 16'd300,            16'd0,     1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_RAMP_PERCENT),    16'd0,     1'b0, 16'sd0},
    '{ROW_ITEM, 16'd10,             16'd0,     1'b0, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_LEVEL_PERCENT),   16'd0,     1'b0, 16'sd0},
    '{ROW_ITEM, 16'd300,            16'd0,     1'b0, 16'sd0},
    // Disabling regen gives zero and clears the stored torque.
    '{ROW_CFG,  16'(rbtr_pkg::REG_REGEN_ON),        16'd0,     1'b0, 16'sd0},
    '{ROW_ITEM, 16'd300,            16'd0,     1'b1, 16'sd0},
    '{ROW_CFG,  16'(rbtr_pkg::REG_REGEN_ON),        16'd1,     1'b0, 16'sd0},
    '{ROW_ITEM, 16'd50,             16'd0,     1'b0, 16'sd0}
  };

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [31:0]                    s_axis_tdata;   // [15:0] motor_speed, [31:16] bus_voltage
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [15:0]                    m_axis_tdata;   // [15:0] regen_torque
  logic                           cfg_we;
  logic [rbtr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rbtr_pkg::CFG_DAT_W-1:0] cfg_wdata;

  // Local copy of the block's registers and stored torque.
  logic                           cfg_en;
  logic [rbtr_pkg::PCT_W-1:0]     cfg_lvl;
  logic signed [15:0]             cfg_cur;
  logic [rbtr_pkg::PCT_W-1:0]     cfg_ramp;
  logic [15:0]                    cfg_vmax;
  logic [rbtr_pkg::MINSPD_W-1:0]  cfg_vmin;
  logic signed [15:0]             torque_mirror;

  // Torque values still owed by the block, oldest first.
  logic signed [15:0]   torque_expq [$];
  int                   fail_count;

  // Idling controls shared by the stimulus and the output side.
  bit                   src_idle_en;
  bit                   sink_idle_en;
  bit                   sink_hold_req;

  regen_braking_torque_ramp u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Advances the stored torque by one item and returns the torque that the
  // block should send for it.
  function automatic logic signed [15:0] next_torque(input logic signed [15:0] spd,
                                                     input logic [15:0] volt);
    longint prod;
    longint quo;
    int     lim;
    int     stp;
    int     nxt;
    if (!cfg_en) begin
      torque_mirror = '0;
      return '0;
    end
    if (cfg_cur > 0 || volt > cfg_vmax || spd <= 0) begin
      return '0;
    end
    prod = longint'(cfg_lvl) * longint'(cfg_cur) * longint'(volt) * TORQUE_K_Q16;
    quo  = prod / (longint'(65536) * longint'(spd));
    if (quo < -32768) quo = -32768;
    if (quo > 0) quo = 0;
    lim = int'(quo);
    stp = (lim * int'(cfg_ramp)) / PCT_SCALE;
    if (2 * int'(spd) > 3 * int'(cfg_vmin)) begin
      // Above 1.5x the minimum speed: step toward the limit, never past it.
      nxt = int'(torque_mirror) + stp;
      torque_mirror = 16'((nxt > lim) ? nxt : lim);
    end else if (int'(spd) < int'(cfg_vmin)) begin
      // Below the minimum speed: step back toward zero, never past it.
      nxt = int'(torque_mirror) - stp;
      torque_mirror = 16'((nxt < 0) ? nxt : 0);
    end
    return torque_mirror;
  endfunction

  function automatic logic [rbtr_pkg::PCT_W-1:0] pick_percent();
    case ($urandom_range(3))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'd127;
      default: return 7'($urandom_range(127, 0));
    endcase
  endfunction

  // One register write, then the enable is driven low again before the task returns,
  // so that back-to-back writes never lower and raise the enable in one step.
  task automatic write_reg(input logic [rbtr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      rbtr_pkg::REG_REGEN_ON:        cfg_en   = data[0];
      rbtr_pkg::REG_LEVEL_PERCENT:   cfg_lvl  = data[rbtr_pkg::PCT_W-1:0];
      rbtr_pkg::REG_MAX_CURRENT:     cfg_cur  = data;
      rbtr_pkg::REG_RAMP_PERCENT:    cfg_ramp = data[rbtr_pkg::PCT_W-1:0];
      rbtr_pkg::REG_MAX_BUS_VOLTAGE: cfg_vmax = data;
      rbtr_pkg::REG_MIN_SPEED:       cfg_vmin = data[rbtr_pkg::MINSPD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Writes every register. Unused upper data bits carry random junk that the
  // block has to drop.
  task automatic load_settings(input logic en, input logic [rbtr_pkg::PCT_W-1:0] lvl,
                               input logic signed [15:0] cur,
                               input logic [rbtr_pkg::PCT_W-1:0] rmp,
                               input logic [15:0] vmax,
                               input logic [rbtr_pkg::MINSPD_W-1:0] vmin);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(rbtr_pkg::REG_REGEN_ON,        {junk[15:1], en});
    write_reg(rbtr_pkg::REG_LEVEL_PERCENT,   {junk[15:7], lvl});
    write_reg(rbtr_pkg::REG_MAX_CURRENT,     cur);
    write_reg(rbtr_pkg::REG_RAMP_PERCENT,    {junk[8:0], rmp});
    write_reg(rbtr_pkg::REG_MAX_BUS_VOLTAGE, vmax);
    write_reg(rbtr_pkg::REG_MIN_SPEED,       {junk[0], vmin});
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_HI, junk);
  endtask

  // Stops offering items and waits until every owed torque has come back.
  // Every item yields exactly one result, so the block is idle by then.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (torque_expq.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Offers one item, waits for the transaction, then records what must come
  // back. tvalid stays high when the next item follows without a gap.
  task automatic push_item(input logic [15:0] spd, input logic [15:0] volt,
                           input logic typed, input logic signed [15:0] want);
    logic signed [15:0] pred;
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {volt, spd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = next_torque(spd, volt);
    torque_expq.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Random item shaped by the current settings. Most speeds are positive and
  // fall around the minimum speed, so the above, hold and below bands are all
  // reached. Most voltages stay at or under the limit.
  task automatic random_item(output logic [15:0] spd, output logic [15:0] volt);
    int pick;
    int top;
    int knee;
    top  = (cfg_vmin == 0) ? 200 : 3 * int'(cfg_vmin);
    if (top > 32767) top = 32767;
    knee = (3 * int'(cfg_vmin)) / 2;
    if (knee > 32766) knee = 32766;
    pick = $urandom_range(99);
    if (pick < 70) begin
      spd = 16'($urandom_range(top, 1));
    end else if (pick < 80) begin
      spd = 16'($urandom);
    end else if (pick < 88) begin
      spd = {1'b1, 15'($urandom)};
    end else if (pick < 92) begin
      spd = 16'd0;
    end else begin
      case ($urandom_range(4))
        0:       spd = 16'd1;
        1:       spd = 16'h7FFF;
        2:       spd = 16'(cfg_vmin);
        3:       spd = 16'(knee);
        default: spd = 16'(knee + 1);
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      volt = 16'($urandom_range((cfg_vmax < 300) ? cfg_vmax : 300, 0));
    end else if (pick < 85) begin
      volt = 16'($urandom_range(cfg_vmax, 0));
    end else begin
      volt = 16'($urandom);
    end
  endtask

  // Output side: random ready with idling, plus a long hold-off on request.
  initial begin : sink_drive
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        hold_left     = HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_en) begin
        m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compares each torque transaction with the oldest owed value.
  always @(posedge clk) begin : torque_check
    logic signed [15:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (torque_expq.size() == 0) begin
        fail_count++;
        $error("regen_torque: expected none, actual %0d", $signed(m_axis_tdata));
      end else begin
        want = torque_expq.pop_front();
        if (m_axis_tdata !== want) begin
          fail_count++;
          $error("regen_torque: expected %0d, actual %0d", want, $signed(m_axis_tdata));
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int                            i;
    int                            ph;
    int                            n;
    int                            pick;
    dir_row_t                      row;
    logic [15:0]                   spd;
    logic [15:0]                   volt;
    logic                          en;
    logic [rbtr_pkg::PCT_W-1:0]    lvl;
    logic [rbtr_pkg::PCT_W-1:0]    rmp;
    logic signed [15:0]            cur;
    logic [15:0]                   vmax;
    logic [rbtr_pkg::MINSPD_W-1:0] vmin;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    cfg_en        = 1'b0;
    cfg_lvl       = '0;
    cfg_cur       = '0;
    cfg_ramp      = '0;
    cfg_vmax      = '0;
    cfg_vmin      = '0;
    torque_mirror = '0;
    fail_count    = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    sink_hold_req = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table. Register writes only happen once the block is idle.
    for (i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_CFG) begin
        drain();
        write_reg(row.a[rbtr_pkg::CFG_IDX_W-1:0], row.b);
      end else begin
        push_item(row.a, row.b, row.typed, row.want);
      end
    end

    // Random phases. The first two use opposite extremes of the settings.
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      if (ph == 0) begin
        load_settings(1'b1, 7'd100, 16'sh8000, 7'd100, 16'hFFFF, 15'd0);
      end else if (ph == 1) begin
        load_settings(1'b1, 7'd1, -16'sd1, 7'd1, 16'hFFFF, 15'h7FFF);
      end else begin
        en  = ($urandom_range(9) != 0);
        lvl = pick_percent();
        rmp = pick_percent();
        pick = $urandom_range(99);
        if (pick < 5)       cur = 16'($urandom_range(32767, 1));
        else if (pick < 10) cur = 16'sd0;
        else if (pick < 20) cur = 16'sh8000;
        else                cur = 16'(-int'($urandom_range(32768, 1)));
        pick = $urandom_range(99);
        if (pick < 10)      vmax = 16'hFFFF;
        else if (pick < 15) vmax = 16'd0;
        else                vmax = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)      vmin = 15'd0;
        else if (pick < 15) vmin = 15'h7FFF;
        else if (pick < 65) vmin = 15'($urandom_range(3000, 1));
        else                vmin = 15'($urandom);
        load_settings(en, lvl, cur, rmp, vmax, vmin);
      end
      // One phase runs flat out on both sides; another starts with a long
      // hold-off on the output so the input side backs up.
      src_idle_en  = (ph != 3);
      sink_idle_en = (ph != 3);
      if (ph == 5) sink_hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        random_item(spd, volt);
        push_item(spd, volt, 1'b0, 16'sd0);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && torque_expq.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
